// ----- rtl/mecanum_wheel_odometry_macros.svh -----
// Assertion macros shared by the odometry checker.
// No dependencies.
`ifndef MECANUM_WHEEL_ODOMETRY_MACROS_SVH
`define MECANUM_WHEEL_ODOMETRY_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define MWO_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mwo check failed");
// Next-cycle implication.
`define MWO_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mwo check failed");
`endif

// ----- rtl/mwo_pkg.sv -----
// Shared types and constants for the mecanum wheel odometry block.
// No dependencies.
`default_nettype none
package mwo_pkg;
    typedef struct packed {
        logic signed [15:0] wheel_front_left;
        logic signed [15:0] wheel_front_right;
        logic signed [15:0] wheel_rear_left;
        logic signed [15:0] wheel_rear_right;
    } t_in;
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [15:0] heading;
        logic signed [15:0] vel_forward;
        logic signed [15:0] vel_side;
        logic signed [15:0] vel_turn;
    } t_out;
    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_INV_SPAN = 2'd1;
    localparam logic [1:0] REG_TICK = 2'd2;
    localparam int CORDIC_STEPS = 16;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [31:0] RAD_TO_TURN32 = 32'sd683565276;
    function automatic logic signed [33:0] atan_turn(input logic [3:0] i);
        case (i)
            4'd0: atan_turn = 34'sd536870912;
            4'd1: atan_turn = 34'sd316933406;
            4'd2: atan_turn = 34'sd167458907;
            4'd3: atan_turn = 34'sd85004756;
            4'd4: atan_turn = 34'sd42667331;
            4'd5: atan_turn = 34'sd21354465;
            4'd6: atan_turn = 34'sd10679838;
            4'd7: atan_turn = 34'sd5340245;
            4'd8: atan_turn = 34'sd2670163;
            4'd9: atan_turn = 34'sd1335087;
            4'd10: atan_turn = 34'sd667544;
            4'd11: atan_turn = 34'sd333772;
            4'd12: atan_turn = 34'sd166886;
            4'd13: atan_turn = 34'sd83443;
            4'd14: atan_turn = 34'sd41722;
            4'd15: atan_turn = 34'sd20861;
            default: atan_turn = 34'sd0;
        endcase
    endfunction
endpackage
`default_nettype wire

// ----- rtl/mwo_cordic.sv -----
// Iterative CORDIC: one rotation step per cycle, cosine and sine in Q1.30.
// Depends on mwo_pkg.
`default_nettype none
module mwo_cordic (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire          [31:0] i_angle,
    output logic                o_done,
    output logic signed  [33:0] o_cos,
    output logic signed  [33:0] o_sin
);
    import mwo_pkg::*;
    logic               r_busy, r_flip;
    logic [3:0]         r_step;
    logic signed [33:0] r_x, r_y, r_z;
    logic signed [33:0] n_x, n_y, n_z, w_ys, w_xs;
    logic [31:0]        w_a;
    logic               w_flip;

    always_comb begin
        w_ys = r_y >>> r_step;
        w_xs = r_x >>> r_step;
        if (!r_z[33]) begin
            n_x = r_x - w_ys;
            n_y = r_y + w_xs;
            n_z = r_z - atan_turn(r_step);
        end else begin
            n_x = r_x + w_ys;
            n_y = r_y - w_xs;
            n_z = r_z + atan_turn(r_step);
        end
        w_flip = i_angle[31] ^ i_angle[30];
        w_a = w_flip ? i_angle + 32'h8000_0000 : i_angle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_step <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_flip <= w_flip;
                r_x <= CORDIC_GAIN;
                r_y <= '0;
                r_z <= {{2{w_a[31]}}, w_a};
            end else if (r_busy) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
                r_step <= r_step + 4'd1;
                if (r_step == 4'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_cos = r_flip ? -r_x : r_x;
    assign o_sin = r_flip ? -r_y : r_y;
endmodule
`default_nettype wire

// ----- rtl/mecanum_wheel_odometry.sv -----
// Mecanum odometry: o_valid rises once the accepted transaction has run through the CORDIC and multiplier states.
// One transaction at a time; o_stall stays high until the result is taken and the block returns to idle.
// Each transaction uses the 16-step CORDIC plus 12 passes through the shared multiplier.
// Synchronous active-low reset clears pose, restores register defaults.
`default_nettype none
module mecanum_wheel_odometry #(
    parameter int ANGLE_BITS = 16,
    parameter int POSITION_BITS = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire  mwo_pkg::t_in  i_data,
    output logic                o_valid,
    input  wire                 i_stall,
    output mwo_pkg::t_out       o_data,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire           [1:0] i_cfg_index,
    input  wire          [15:0] i_cfg_data
);
    import mwo_pkg::*;
    typedef enum logic [4:0] {
        S_IDLE, S_VF, S_VS, S_VT1, S_VT2, S_CORD, S_RX1, S_RX2, S_RY1, S_RY2,
        S_DX, S_DY, S_DT1, S_DT2, S_DT3, S_ACC, S_OUT
    } t_state;
    t_state r_state;
    logic [15:0] r_radius, r_inv, r_tick;
    logic [POSITION_BITS-1:0] r_x, r_y;
    logic [ANGLE_BITS-1:0] r_th;
    logic signed [17:0] r_ss, r_st;
    logic signed [15:0] r_vf, r_vs, r_vt;
    logic signed [63:0] r_prod, r_tmp, r_rx, r_dx, r_dy;
    logic signed [34:0] r_ma, r_mb;
    logic signed [63:0] w_mul;
    logic cord_start, cord_done;
    logic signed [33:0] cord_c, cord_s;

    assign w_mul = 64'(r_ma * r_mb);

    function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
        rnd = (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction
    function automatic logic signed [15:0] sat(input logic signed [63:0] v);
        if (v > 64'sd32767) sat = 16'sh7fff;
        else if (v < -64'sd32768) sat = 16'sh8000;
        else sat = v[15:0];
    endfunction

    assign cord_start = (r_state == S_VF);
    mwo_cordic u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(cord_start),
        .i_angle(32'({r_th, {(32 - ANGLE_BITS){1'b0}}})),
        .o_done(cord_done), .o_cos(cord_c), .o_sin(cord_s)
    );

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_radius <= 16'd3277;
            r_inv <= 16'd1280;
            r_tick <= 16'd655;
            r_x <= '0;
            r_y <= '0;
            r_th <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_RADIUS:   r_radius <= i_cfg_data;
                    REG_INV_SPAN: r_inv <= i_cfg_data;
                    REG_TICK:     r_tick <= i_cfg_data;
                    default: ;
                endcase
            end
            r_prod <= w_mul;
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_ss <= -18'(i_data.wheel_front_left) + i_data.wheel_front_right
                          + i_data.wheel_rear_left - i_data.wheel_rear_right;
                    r_st <= 18'(i_data.wheel_front_left) - i_data.wheel_front_right
                          - i_data.wheel_rear_left + i_data.wheel_rear_right;
                    r_ma <= 35'(18'(i_data.wheel_front_left) + i_data.wheel_front_right
                          + i_data.wheel_rear_left + i_data.wheel_rear_right);
                    r_mb <= 35'({1'b0, r_radius});
                    r_state <= S_VF;
                end
                S_VF: begin
                    r_ma <= 35'(r_ss);
                    r_state <= S_VS;
                end
                S_VS: begin
                    r_vf <= sat(rnd(r_prod, 18));
                    r_ma <= 35'(r_st);
                    r_state <= S_VT1;
                end
                S_VT1: begin
                    r_vs <= sat(rnd(r_prod, 18));
                    r_state <= S_VT2;
                end
                S_VT2: begin
                    r_ma <= 35'(r_prod);
                    r_mb <= 35'({1'b0, r_inv});
                    r_state <= S_CORD;
                end
                S_CORD: if (cord_done) begin
                    r_vt <= sat(rnd(r_prod, 26));
                    r_ma <= 35'(r_vf);
                    r_mb <= 35'(cord_c);
                    r_state <= S_RX1;
                end
                S_RX1: begin
                    r_mb <= 35'(cord_s);
                    r_ma <= 35'(r_vs);
                    r_state <= S_RX2;
                end
                S_RX2: begin
                    r_tmp <= r_prod;
                    r_ma <= 35'(r_vf);
                    r_state <= S_RY1;
                end
                S_RY1: begin
                    r_rx <= rnd(r_tmp - r_prod, 22);
                    r_ma <= 35'(r_vs);
                    r_mb <= 35'(cord_c);
                    r_state <= S_RY2;
                end
                S_RY2: begin
                    r_tmp <= r_prod;
                    r_ma <= 35'(r_rx);
                    r_mb <= 35'({1'b0, r_tick});
                    r_state <= S_DX;
                end
                S_DX: begin
                    r_ma <= 35'(rnd(r_tmp + r_prod, 22));
                    r_state <= S_DY;
                end
                S_DY: begin
                    r_dx <= rnd(r_prod, 16);
                    r_ma <= 35'(r_vt);
                    r_state <= S_DT1;
                end
                S_DT1: begin
                    r_dy <= rnd(r_prod, 16);
                    r_state <= S_DT2;
                end
                S_DT2: begin
                    r_ma <= 35'(r_prod);
                    r_mb <= 35'(RAD_TO_TURN32);
                    r_state <= S_DT3;
                end
                // wait for the heading product to be registered
                S_DT3: r_state <= S_ACC;
                S_ACC: begin
                    r_x <= r_x + r_dx[POSITION_BITS-1:0];
                    r_y <= r_y + r_dy[POSITION_BITS-1:0];
                    r_th <= r_th + ANGLE_BITS'(rnd(r_prod, 56 - ANGLE_BITS));
                    r_state <= S_OUT;
                end
                S_OUT: if (!i_stall) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_data.pos_x = 32'(signed'(r_x));
        o_data.pos_y = 32'(signed'(r_y));
        o_data.heading = 16'(r_th);
        o_data.vel_forward = r_vf;
        o_data.vel_side = r_vs;
        o_data.vel_turn = r_vt;
    end
endmodule
`default_nettype wire

// ----- rtl/mwo_checker.sv -----
// Port-level checks for the odometry block, bound to the top level.
// Depends on mecanum_wheel_odometry_macros.svh.
`default_nettype none
`include "mecanum_wheel_odometry_macros.svh"
module mwo_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_valid,
    input wire o_stall,
    input wire o_valid,
    input wire i_stall
);
    `MWO_ASSERT_IMP(a_busy_out, i_clk, i_rst_n, o_valid, o_stall)
    `MWO_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall && !o_valid)
    `MWO_ASSERT_NXT(a_hold_out, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `MWO_ASSERT_NXT(a_free, i_clk, i_rst_n, o_valid && !i_stall, !o_stall)
endmodule
bind mecanum_wheel_odometry mwo_checker u_mwo_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall)
);
`default_nettype wire

// ----- tb/tb_mecanum_wheel_odometry.sv -----
// Self-checking testbench for mecanum_wheel_odometry: drives wheel speed samples,
// predicts pose and body velocities per sample and checks each result in order.
// Depends on mwo_pkg and the mecanum_wheel_odometry RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_mecanum_wheel_odometry;
    import mwo_pkg::*;

    localparam int      LIMIT_CYCLES = 1000000;
    localparam int      SETTLE_CYCLES = 40;
    localparam int      MAX_REPORTS = 10;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam longint  GAIN_Q30 = 64'sd652032874;
    localparam longint  TURN_PER_RAD = 64'sd683565276;
    localparam longint  ATAN_TBL [16] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in         i_data;
    logic        o_valid;
    logic        i_stall;
    t_out        o_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    mecanum_wheel_odometry uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [15:0] radius_q16;
    logic [15:0] inv_span_q8;
    logic [15:0] tick_q16;
    logic [31:0] x_acc;
    logic [31:0] y_acc;
    logic [15:0] heading_acc;

    t_out expected_pose[$];
    int   mismatch_count = 0;
    int   cycle_count = 0;
    int   stall_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // 16-step rotation on a 32-bit angle, folded into the right half plane first
    task automatic sin_cos(input logic [31:0] angle, output longint c, output longint s);
        logic [31:0] a;
        logic [31:0] probe;
        logic        flip;
        longint      x, y, z, nx;
        a = angle;
        flip = 1'b0;
        probe = a + 32'h4000_0000;
        if (probe[31]) begin
            a = a + 32'h8000_0000;
            flip = 1'b1;
        end
        z = longint'(signed'(a));
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - ATAN_TBL[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + ATAN_TBL[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic advance_pose(input t_in w, output t_out p);
        longint fl, fr, rl, rr, r, dt, vf, vs, vt, c, s, rx, ry, dx, dy, dth;
        fl = longint'(w.wheel_front_left);
        fr = longint'(w.wheel_front_right);
        rl = longint'(w.wheel_rear_left);
        rr = longint'(w.wheel_rear_right);
        r = longint'(radius_q16);
        dt = longint'(tick_q16);
        vf = clamp16(round_shift((fl + fr + rl + rr) * r, 18));
        vs = clamp16(round_shift((-fl + fr + rl - rr) * r, 18));
        vt = clamp16(round_shift((fl - fr - rl + rr) * r * longint'(inv_span_q8), 26));
        // rotate by the heading held before this sample
        sin_cos({heading_acc, 16'h0000}, c, s);
        rx = round_shift(vf * c - vs * s, 22);
        ry = round_shift(vf * s + vs * c, 22);
        dx = round_shift(rx * dt, 16);
        dy = round_shift(ry * dt, 16);
        dth = round_shift(vt * dt * TURN_PER_RAD, 40);
        x_acc = x_acc + dx[31:0];
        y_acc = y_acc + dy[31:0];
        heading_acc = heading_acc + dth[15:0];
        p.pos_x = x_acc;
        p.pos_y = y_acc;
        p.heading = heading_acc;
        p.vel_forward = vf[15:0];
        p.vel_side = vs[15:0];
        p.vel_turn = vt[15:0];
    endtask

    function automatic void report_field(input string name, input longint e, input longint a);
        if (e != a) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("mismatch %s: expected %0d got %0d", name, e, a);
        end
    endfunction

    // receive side: random stall with quiet stretches, check on each transaction
    always @(posedge i_clk) begin
        t_out exp_p;
        int   r;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_pose.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result %h", o_data);
                end else begin
                    exp_p = expected_pose.pop_front();
                    report_field("pos_x", exp_p.pos_x, o_data.pos_x);
                    report_field("pos_y", exp_p.pos_y, o_data.pos_y);
                    report_field("heading", exp_p.heading, o_data.heading);
                    report_field("vel_forward", exp_p.vel_forward, o_data.vel_forward);
                    report_field("vel_side", exp_p.vel_side, o_data.vel_side);
                    report_field("vel_turn", exp_p.vel_turn, o_data.vel_turn);
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_stall <= 1'b1;
            end else if (cycle_count[12]) begin
                i_stall <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    i_stall <= 1'b0;
                end else if (r < 96) begin
                    stall_left <= $urandom_range(0, 3);
                    i_stall <= 1'b1;
                end else begin
                    stall_left <= $urandom_range(20, 60);
                    i_stall <= 1'b1;
                end
            end
        end
    end

    task automatic send_sample(input t_in w);
        t_out p;
        int   gap;
        int   r;
        r = $urandom_range(0, 99);
        if (cycle_count[11] || r < 55) gap = 0;
        else if (r < 95) gap = $urandom_range(1, 4);
        else gap = $urandom_range(20, 60);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= w;
        do @(posedge i_clk); while (o_stall);
        advance_pose(w, p);
        expected_pose.push_back(p);
    endtask

    // hold until every result is back and the pipeline has emptied
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_pose.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_RADIUS:   radius_q16 = value;
            REG_INV_SPAN: inv_span_q8 = value;
            REG_TICK:     tick_q16 = value;
            default:      ;
        endcase
    endtask

    function automatic t_in make_sample(input int fl, input int fr, input int rl,
                                        input int rr);
        t_in w;
        w.wheel_front_left = fl[15:0];
        w.wheel_front_right = fr[15:0];
        w.wheel_rear_left = rl[15:0];
        w.wheel_rear_right = rr[15:0];
        return w;
    endfunction

    function automatic int random_speed();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 65535) - 32768;
            1: return $urandom_range(0, 1023) - 512;
            2: return $urandom_range(0, 1) ? 32767 : -32768;
            default: return $urandom_range(0, 8191) - 4096;
        endcase
    endfunction

    task automatic test_directed_extremes();
        send_sample(make_sample(0, 0, 0, 0));
        send_sample(make_sample(32767, 32767, 32767, 32767));
        send_sample(make_sample(-32768, -32768, -32768, -32768));
        send_sample(make_sample(-32768, 32767, 32767, -32768));
        send_sample(make_sample(32767, -32768, -32768, 32767));
        send_sample(make_sample(256, 0, 0, 0));
        send_sample(make_sample(0, 256, 0, 0));
        send_sample(make_sample(0, 0, 256, 0));
        send_sample(make_sample(0, 0, 0, 256));
        send_sample(make_sample(-1, -1, -1, -1));
        send_sample(make_sample(1, 1, 1, 1));
        // spin in place to carry the heading from near zero into the second quadrant
        repeat (8) send_sample(make_sample(32767, -32768, -32768, 32767));
        send_sample(make_sample(2560, 2560, 2560, 2560));
        send_sample(make_sample(-2560, 2560, 2560, -2560));
    endtask

    task automatic test_register_extremes();
        write_reg(REG_RADIUS, 16'hFFFF);
        write_reg(REG_INV_SPAN, 16'hFFFF);
        write_reg(REG_TICK, 16'hFFFF);
        // saturating velocities, full tick: drives large position steps and heading wrap
        repeat (6) send_sample(make_sample(32767, 32767, 32767, 32767));
        repeat (6) send_sample(make_sample(32767, -32768, -32768, 32767));
        repeat (4) send_sample(make_sample(-32768, 32767, 32767, -32768));
        write_reg(REG_UNUSED, 16'h1234);
        send_sample(make_sample(1000, -2000, 3000, -4000));
        write_reg(REG_RADIUS, 16'h0000);
        write_reg(REG_INV_SPAN, 16'h0000);
        write_reg(REG_TICK, 16'h0000);
        send_sample(make_sample(32767, 32767, -32768, 12345));
    endtask

    task automatic test_random_motion();
        int fwd, side, turn;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_RADIUS, 16'd3277);
                    write_reg(REG_INV_SPAN, 16'd1280);
                    write_reg(REG_TICK, 16'd655);
                end
                1: begin
                    write_reg(REG_RADIUS, 16'hFFFF);
                    write_reg(REG_TICK, 16'hFFFF);
                end
                default: begin
                    write_reg(REG_RADIUS, 16'($urandom_range(0, 65535)));
                    write_reg(REG_INV_SPAN, 16'($urandom_range(0, 65535)));
                    write_reg(REG_TICK, 16'($urandom_range(0, 65535)));
                end
            endcase
            for (int n = 0; n < 220; n++) begin
                if ($urandom_range(0, 3) != 0) begin
                    // coherent motion: common forward, side and turn parts per wheel
                    fwd = $urandom_range(0, 16383) - 8192;
                    side = $urandom_range(0, 16383) - 8192;
                    turn = $urandom_range(0, 16383) - 8192;
                    send_sample(make_sample(fwd - side + turn, fwd + side - turn,
                                            fwd + side - turn, fwd - side + turn));
                end else begin
                    send_sample(make_sample(random_speed(), random_speed(),
                                            random_speed(), random_speed()));
                end
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_RADIUS;
        i_cfg_data <= '0;
        radius_q16 = 16'd3277;
        inv_span_q8 = 16'd1280;
        tick_q16 = 16'd655;
        x_acc = '0;
        y_acc = '0;
        heading_acc = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_register_extremes();
        test_random_motion();
        wait_idle();

        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
